@@ design/mpf_pkg.sv @@
package mpf_pkg;

   localparam int WORD_W    = 32;
   localparam int QUO_W     = 32;
   localparam int STEP_D    = QUO_W + 1;
   localparam int NUM_W     = 49;
   localparam int RAD_W     = 64;
   localparam int REQ_W     = 304;
   localparam int RSP_W     = 160;

   localparam logic [30:0] Q_ONE_CFG = 31'd65536;
   localparam logic [16:0] WGT_ONE   = 17'd65536;
   localparam logic signed [32:0] Q_HALF = 33'sd32768;

   typedef enum logic [2:0] {
      CSR_ATTRACT = 3'd0,
      CSR_REPULSE = 3'd1,
      CSR_DRAG    = 3'd2,
      CSR_NOISE   = 3'd3,
      CSR_OUTER   = 3'd4,
      CSR_INNER   = 3'd5,
      CSR_NSCALE  = 3'd6,
      CSR_ENERGY  = 3'd7
   } csr_index_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] a);
      return a[31] ? (~a + 32'd1) : a;
   endfunction

   function automatic logic signed [35:0] sx36(input logic signed [31:0] a);
      return {{4{a[31]}}, a};
   endfunction

   function automatic logic signed [31:0] sat_mag(input logic [63:0] m, input logic neg);
      logic [63:0] nm;
      nm = ~m + 64'd1;
      if (neg) begin
         return (m > 64'h8000_0000) ? 32'sh8000_0000 : nm[31:0];
      end
      return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sh0_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < 36'shF_8000_0000) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] qmul(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
      logic [32:0] ma;
      logic [32:0] mb;
      logic [63:0] prod;
      ma   = a[32] ? (~a + 33'd1) : a;
      mb   = b[32] ? (~b + 33'd1) : b;
      prod = 64'(ma[31:0]) * 64'(mb[31:0]);
      return sat_mag((prod + 64'h8000) >> 16, a[32] ^ b[32]);
   endfunction

   function automatic logic signed [31:0] sdiv(input logic [31:0] q, input logic ovf,
                                               input logic neg);
      return sat_mag(ovf ? 64'hFFFF_FFFF_FFFF_FFFF : {32'h0, q}, neg);
   endfunction

endpackage

@@ design/mpf_sqrt.sv @@
module mpf_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [31:0] root
);

   logic [63:0] rem_ff  [0:mpf_pkg::QUO_W];
   logic [31:0] root_ff [0:mpf_pkg::QUO_W];
   logic [63:0] rem_in  [1:mpf_pkg::QUO_W];
   logic [31:0] root_in [1:mpf_pkg::QUO_W];

   always_comb begin
      logic [65:0] trial;
      for (int k = 0; k < mpf_pkg::QUO_W; k++) begin
         trial = (66'(root_ff[k]) << (mpf_pkg::QUO_W - k))
               + (66'd1 << (2 * (mpf_pkg::QUO_W - 1 - k)));
         if (66'(rem_ff[k]) >= trial) begin
            rem_in[k+1]  = 64'(66'(rem_ff[k]) - trial);
            root_in[k+1] = root_ff[k] | (32'd1 << (mpf_pkg::QUO_W - 1 - k));
         end else begin
            rem_in[k+1]  = rem_ff[k];
            root_in[k+1] = root_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rad;
         root_ff[0] <= '0;
         for (int k = 1; k <= mpf_pkg::QUO_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign root = root_ff[mpf_pkg::QUO_W];

endmodule

@@ design/mpf_div.sv @@
module mpf_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [mpf_pkg::NUM_W-1:0]  num,
   input  logic [31:0]                den,
   output logic [31:0]                quot,
   output logic                       ovf
);

   logic [mpf_pkg::NUM_W-1:0] rem_ff [0:mpf_pkg::QUO_W];
   logic [31:0]               den_ff [0:mpf_pkg::QUO_W];
   logic [31:0]               q_ff   [0:mpf_pkg::QUO_W];
   logic                      ovf_ff [0:mpf_pkg::QUO_W];
   logic [mpf_pkg::NUM_W-1:0] rem_in [1:mpf_pkg::QUO_W];
   logic [31:0]               q_in   [1:mpf_pkg::QUO_W];

   always_comb begin
      logic [63:0] sub;
      for (int k = 0; k < mpf_pkg::QUO_W; k++) begin
         sub = 64'(den_ff[k]) << (mpf_pkg::QUO_W - 1 - k);
         if (64'(rem_ff[k]) >= sub) begin
            rem_in[k+1] = mpf_pkg::NUM_W'(64'(rem_ff[k]) - sub);
            q_in[k+1]   = q_ff[k] | (32'd1 << (mpf_pkg::QUO_W - 1 - k));
         end else begin
            rem_in[k+1] = rem_ff[k];
            q_in[k+1]   = q_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= ({16'h0, num} >= {1'b0, den, 32'h0});
         for (int k = 1; k <= mpf_pkg::QUO_W; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_ff[k-1];
            q_ff[k]   <= q_in[k];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quot = q_ff[mpf_pkg::QUO_W];
   assign ovf  = ovf_ff[mpf_pkg::QUO_W];

endmodule

@@ design/mdpd_pair_force_core.sv @@
// Pair force pipeline for many-body dissipative particle dynamics.
// The req channel takes one neighbor pair per item: distance and velocity
// differences, both densities, a Gaussian sample and the bond factor. The
// rsp channel returns one item per pair: force vector, scalar force, pair
// energy and, on tuser, the in-range flag. Coefficients and cutoffs come in
// through the csr write port and must only change while no item is in flight.
// It accepts one item per cycle while req_tready is high. The time from the
// accepting edge to rsp_tvalid is set by the square root unit and the long
// dividers (a parallel pair, then two more in a chain), each 33 register
// stages deep with a result bit per stage after the first, plus multiply stages.
// Reset clears all valid bits and loads the csr reset values; the block is
// ready as soon as reset drops.
// When rsp_tready is low the result holds in the output register and one more
// item moves into a skid register; after that req_tready drops and the whole
// pipeline holds without losing or repeating any item.
module mdpd_pair_force_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // dist_x, dist_y, dist_z, vel_diff_x, vel_diff_y, vel_diff_z, density_i,
   // density_j, gauss_sample, bond_factor, zero pad
   input  logic [mpf_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // force_x, force_y, force_z, force_scalar, pair_energy
   output logic [mpf_pkg::RSP_W-1:0]  rsp_tdata,
   // in_range
   output logic                       rsp_tuser,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_index,
   input  logic [31:0]                csr_wdata
);

   typedef struct packed {
      logic               vld;
      logic signed [31:0] dx, dy, dz, vx, vy, vz;
      logic [30:0]        di, dj;
      logic signed [31:0] gs;
      logic [16:0]        bond;
   } a_stage_type;

   typedef struct packed {
      logic               vld;
      logic [63:0]        sqx, sqy, sqz;
      logic signed [31:0] tx, ty, tz;
      logic [30:0]        rho;
      logic [61:0]        ocsq;
      logic signed [31:0] dx, dy, dz, gs;
      logic [16:0]        bond;
   } b_stage_type;

   typedef struct packed {
      logic               vld;
      logic [63:0]        rsq;
      logic [61:0]        ocsq;
      logic signed [31:0] dot, dx, dy, dz, gs;
      logic [30:0]        rho;
      logic [16:0]        bond;
   } c_stage_type;

   typedef struct packed {
      logic               vld;
      logic               hit;
      logic signed [31:0] dx, dy, dz, dot, gs;
      logic [30:0]        rho;
      logic [16:0]        bond;
   } pair_type;

   typedef struct packed {
      pair_type    p;
      logic [31:0] r;
   } rpair_type;

   typedef struct packed {
      rpair_type   q;
      logic [16:0] wc, wcr;
   } w_stage_type;

   typedef struct packed {
      rpair_type          q;
      logic [16:0]        wcr;
      logic signed [31:0] wc2, a1, trep, n1, wcr2, ea;
   } m1_stage_type;

   typedef struct packed {
      rpair_type          q;
      logic signed [31:0] a1, wcr2, cons_b, d1, n2, e1a, er;
   } m2_stage_type;

   typedef struct packed {
      rpair_type          q;
      logic signed [31:0] cons, dq, n3, e1, er2, wcr2;
   } m3_stage_type;

   typedef struct packed {
      logic               vld;
      logic               hit;
      logic signed [31:0] dx, dy, dz;
      logic [16:0]        bond;
      logic [31:0]        r;
      logic signed [31:0] cons, n3, e1, er2, wcr2;
      logic               neg;
   } drag_pl_type;

   typedef struct packed {
      logic               vld;
      logic               hit;
      logic signed [31:0] dx, dy, dz;
      logic [16:0]        bond;
      logic [31:0]        r;
      logic signed [31:0] f, e1, e2a;
   } f1_stage_type;

   typedef struct packed {
      logic               vld;
      logic               hit;
      logic signed [31:0] dx, dy, dz;
      logic [16:0]        bond;
      logic [31:0]        r;
      logic signed [31:0] fb, e1, e2;
   } f2_stage_type;

   typedef struct packed {
      logic               vld;
      logic               hit;
      logic signed [31:0] dx, dy, dz;
      logic [16:0]        bond;
      logic signed [31:0] e1, e2;
      logic               neg;
   } fs_pl_type;

   typedef struct packed {
      logic               vld;
      logic               hit;
      logic signed [31:0] dx, dy, dz;
      logic [16:0]        bond;
      logic signed [31:0] fs, esum;
   } g1_stage_type;

   typedef struct packed {
      logic signed [31:0] energy, fs, fz, fy, fx;
      logic               hit;
   } rsp_type;

   typedef struct packed {
      logic    vld;
      rsp_type d;
   } g2_stage_type;

   logic signed [31:0] attract_ff, repulse_ff;
   logic [30:0]        drag_ff, noise_ff, outer_ff, inner_ff, nscale_ff;
   logic               energy_en_ff;

   logic en;

   a_stage_type  a_ff,  a_in;
   b_stage_type  b_ff,  b_in;
   c_stage_type  c_ff,  c_in;
   pair_type     p1_ff [0:mpf_pkg::STEP_D-1];
   pair_type     p1_in;
   rpair_type    p2_ff [0:mpf_pkg::STEP_D-1];
   rpair_type    p2_in;
   w_stage_type  w_ff,  w_in;
   m1_stage_type m1_ff, m1_in;
   m2_stage_type m2_ff, m2_in;
   m3_stage_type m3_ff, m3_in;
   drag_pl_type  p3_ff [0:mpf_pkg::STEP_D-1];
   drag_pl_type  p3_in;
   f1_stage_type f1_ff, f1_in;
   f2_stage_type f2_ff, f2_in;
   fs_pl_type    p4_ff [0:mpf_pkg::STEP_D-1];
   fs_pl_type    p4_in;
   g1_stage_type g1_ff, g1_in;
   g2_stage_type g2_ff, g2_in;

   rsp_type out_ff, skid_ff;
   logic    out_vld_ff, skid_vld_ff;

   logic [31:0]               sq_root;
   logic [mpf_pkg::NUM_W-1:0] num_wc, num_wcr, num_drag, num_fs;
   logic [31:0]               q_wc, q_wcr, q_drag, q_fs;
   logic                      ovf_wc, ovf_wcr, ovf_drag, ovf_fs;
   logic signed [31:0]        drag_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         attract_ff   <= '0;
         repulse_ff   <= '0;
         drag_ff      <= '0;
         noise_ff     <= '0;
         outer_ff     <= mpf_pkg::Q_ONE_CFG;
         inner_ff     <= mpf_pkg::Q_ONE_CFG;
         nscale_ff    <= mpf_pkg::Q_ONE_CFG;
         energy_en_ff <= 1'b0;
      end else if (csr_we) begin
         case (mpf_pkg::csr_index_type'(csr_index))
            mpf_pkg::CSR_ATTRACT: attract_ff   <= csr_wdata;
            mpf_pkg::CSR_REPULSE: repulse_ff   <= csr_wdata;
            mpf_pkg::CSR_DRAG:    drag_ff      <= csr_wdata[30:0];
            mpf_pkg::CSR_NOISE:   noise_ff     <= csr_wdata[30:0];
            mpf_pkg::CSR_OUTER:   outer_ff     <= csr_wdata[30:0];
            mpf_pkg::CSR_INNER:   inner_ff     <= csr_wdata[30:0];
            mpf_pkg::CSR_NSCALE:  nscale_ff    <= csr_wdata[30:0];
            mpf_pkg::CSR_ENERGY:  energy_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign en         = !skid_vld_ff;
   assign req_tready = en && !reset;

   always_comb begin
      a_in.vld  = req_tvalid;
      a_in.dx   = req_tdata[31:0];
      a_in.dy   = req_tdata[63:32];
      a_in.dz   = req_tdata[95:64];
      a_in.vx   = req_tdata[127:96];
      a_in.vy   = req_tdata[159:128];
      a_in.vz   = req_tdata[191:160];
      a_in.di   = req_tdata[222:192];
      a_in.dj   = req_tdata[253:223];
      a_in.gs   = req_tdata[285:254];
      a_in.bond = req_tdata[302:286];
   end

   always_comb begin
      logic [31:0] rho_sum;
      rho_sum   = 32'(a_ff.di) + 32'(a_ff.dj);
      b_in.vld  = a_ff.vld;
      b_in.sqx  = 64'(mpf_pkg::mag32(a_ff.dx)) * 64'(mpf_pkg::mag32(a_ff.dx));
      b_in.sqy  = 64'(mpf_pkg::mag32(a_ff.dy)) * 64'(mpf_pkg::mag32(a_ff.dy));
      b_in.sqz  = 64'(mpf_pkg::mag32(a_ff.dz)) * 64'(mpf_pkg::mag32(a_ff.dz));
      b_in.tx   = mpf_pkg::qmul({a_ff.dx[31], a_ff.dx}, {a_ff.vx[31], a_ff.vx});
      b_in.ty   = mpf_pkg::qmul({a_ff.dy[31], a_ff.dy}, {a_ff.vy[31], a_ff.vy});
      b_in.tz   = mpf_pkg::qmul({a_ff.dz[31], a_ff.dz}, {a_ff.vz[31], a_ff.vz});
      b_in.rho  = rho_sum[31] ? 31'h7FFF_FFFF : rho_sum[30:0];
      b_in.ocsq = 62'(outer_ff) * 62'(outer_ff);
      b_in.dx   = a_ff.dx;
      b_in.dy   = a_ff.dy;
      b_in.dz   = a_ff.dz;
      b_in.gs   = a_ff.gs;
      b_in.bond = a_ff.bond;
   end

   always_comb begin
      c_in.vld  = b_ff.vld;
      c_in.rsq  = b_ff.sqx + b_ff.sqy + b_ff.sqz;
      c_in.ocsq = b_ff.ocsq;
      c_in.dot  = mpf_pkg::sat32(mpf_pkg::sx36(b_ff.tx) + mpf_pkg::sx36(b_ff.ty)
                                 + mpf_pkg::sx36(b_ff.tz));
      c_in.dx   = b_ff.dx;
      c_in.dy   = b_ff.dy;
      c_in.dz   = b_ff.dz;
      c_in.gs   = b_ff.gs;
      c_in.rho  = b_ff.rho;
      c_in.bond = b_ff.bond;
   end

   always_comb begin
      p1_in.vld  = c_ff.vld;
      p1_in.hit  = (outer_ff != '0) && (c_ff.rsq < {2'b00, c_ff.ocsq}) && (c_ff.rsq != '0);
      p1_in.dx   = c_ff.dx;
      p1_in.dy   = c_ff.dy;
      p1_in.dz   = c_ff.dz;
      p1_in.dot  = c_ff.dot;
      p1_in.gs   = c_ff.gs;
      p1_in.rho  = c_ff.rho;
      p1_in.bond = c_ff.bond;
   end

   mpf_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (c_ff.rsq),
      .root  (sq_root)
   );

   assign p2_in.p = p1_ff[mpf_pkg::STEP_D-1];
   assign p2_in.r = sq_root;

   assign num_wc  = mpf_pkg::NUM_W'({sq_root, 16'h0}) + mpf_pkg::NUM_W'(outer_ff[30:1]);
   assign num_wcr = mpf_pkg::NUM_W'({sq_root, 16'h0}) + mpf_pkg::NUM_W'(inner_ff[30:1]);

   mpf_div u_div_wc (
      .clock (clock),
      .en    (en),
      .num   (num_wc),
      .den   ({1'b0, outer_ff}),
      .quot  (q_wc),
      .ovf   (ovf_wc)
   );

   mpf_div u_div_wcr (
      .clock (clock),
      .en    (en),
      .num   (num_wcr),
      .den   ({1'b0, inner_ff}),
      .quot  (q_wcr),
      .ovf   (ovf_wcr)
   );

   always_comb begin
      w_in.q   = p2_ff[mpf_pkg::STEP_D-1];
      w_in.wc  = (ovf_wc || (q_wc >= 32'd65536)) ? '0
               : mpf_pkg::WGT_ONE - {1'b0, q_wc[15:0]};
      w_in.wcr = ((inner_ff == '0) || ovf_wcr || (q_wcr >= 32'd65536)) ? '0
               : mpf_pkg::WGT_ONE - {1'b0, q_wcr[15:0]};
   end

   always_comb begin
      m1_in.q    = w_ff.q;
      m1_in.wcr  = w_ff.wcr;
      m1_in.wc2  = mpf_pkg::qmul({16'h0, w_ff.wc}, {16'h0, w_ff.wc});
      m1_in.a1   = mpf_pkg::qmul({attract_ff[31], attract_ff}, {16'h0, w_ff.wc});
      m1_in.trep = mpf_pkg::qmul({repulse_ff[31], repulse_ff}, {2'b00, w_ff.q.p.rho});
      m1_in.n1   = mpf_pkg::qmul({2'b00, noise_ff}, {16'h0, w_ff.wc});
      m1_in.wcr2 = mpf_pkg::qmul({16'h0, w_ff.wcr}, {16'h0, w_ff.wcr});
      m1_in.ea   = mpf_pkg::qmul({attract_ff[31], attract_ff}, {2'b00, outer_ff});
   end

   always_comb begin
      m2_in.q      = m1_ff.q;
      m2_in.a1     = m1_ff.a1;
      m2_in.wcr2   = m1_ff.wcr2;
      m2_in.cons_b = mpf_pkg::qmul({m1_ff.trep[31], m1_ff.trep}, {16'h0, m1_ff.wcr});
      m2_in.d1     = mpf_pkg::qmul({2'b00, drag_ff}, {m1_ff.wc2[31], m1_ff.wc2});
      m2_in.n2     = mpf_pkg::qmul({m1_ff.n1[31], m1_ff.n1},
                                   {m1_ff.q.p.gs[31], m1_ff.q.p.gs});
      m2_in.e1a    = mpf_pkg::qmul({m1_ff.ea[31], m1_ff.ea}, {m1_ff.wc2[31], m1_ff.wc2});
      m2_in.er     = mpf_pkg::qmul({repulse_ff[31], repulse_ff}, {2'b00, inner_ff});
   end

   always_comb begin
      m3_in.q    = m2_ff.q;
      m3_in.wcr2 = m2_ff.wcr2;
      m3_in.cons = mpf_pkg::sat32(mpf_pkg::sx36(m2_ff.a1) + mpf_pkg::sx36(m2_ff.cons_b));
      m3_in.dq   = mpf_pkg::qmul({m2_ff.d1[31], m2_ff.d1},
                                 {m2_ff.q.p.dot[31], m2_ff.q.p.dot});
      m3_in.n3   = mpf_pkg::qmul({m2_ff.n2[31], m2_ff.n2}, {2'b00, nscale_ff});
      m3_in.e1   = mpf_pkg::qmul({m2_ff.e1a[31], m2_ff.e1a}, mpf_pkg::Q_HALF);
      m3_in.er2  = mpf_pkg::qmul({m2_ff.er[31], m2_ff.er}, {2'b00, m2_ff.q.p.rho});
   end

   assign num_drag = mpf_pkg::NUM_W'({mpf_pkg::mag32(m3_ff.dq), 16'h0})
                   + mpf_pkg::NUM_W'(m3_ff.q.r[31:1]);

   mpf_div u_div_drag (
      .clock (clock),
      .en    (en),
      .num   (num_drag),
      .den   (m3_ff.q.r),
      .quot  (q_drag),
      .ovf   (ovf_drag)
   );

   always_comb begin
      p3_in.vld  = m3_ff.q.p.vld;
      p3_in.hit  = m3_ff.q.p.hit;
      p3_in.dx   = m3_ff.q.p.dx;
      p3_in.dy   = m3_ff.q.p.dy;
      p3_in.dz   = m3_ff.q.p.dz;
      p3_in.bond = m3_ff.q.p.bond;
      p3_in.r    = m3_ff.q.r;
      p3_in.cons = m3_ff.cons;
      p3_in.n3   = m3_ff.n3;
      p3_in.e1   = m3_ff.e1;
      p3_in.er2  = m3_ff.er2;
      p3_in.wcr2 = m3_ff.wcr2;
      p3_in.neg  = m3_ff.dq[31];
   end

   assign drag_val = mpf_pkg::sdiv(q_drag, ovf_drag, p3_ff[mpf_pkg::STEP_D-1].neg);

   always_comb begin
      drag_pl_type t;
      t         = p3_ff[mpf_pkg::STEP_D-1];
      f1_in.vld = t.vld;
      f1_in.hit = t.hit;
      f1_in.dx  = t.dx;
      f1_in.dy  = t.dy;
      f1_in.dz  = t.dz;
      f1_in.bond = t.bond;
      f1_in.r   = t.r;
      f1_in.f   = mpf_pkg::sat32(mpf_pkg::sx36(t.cons) - mpf_pkg::sx36(drag_val)
                                 + mpf_pkg::sx36(t.n3));
      f1_in.e1  = t.e1;
      f1_in.e2a = mpf_pkg::qmul({t.er2[31], t.er2}, {t.wcr2[31], t.wcr2});
   end

   always_comb begin
      f2_in.vld  = f1_ff.vld;
      f2_in.hit  = f1_ff.hit;
      f2_in.dx   = f1_ff.dx;
      f2_in.dy   = f1_ff.dy;
      f2_in.dz   = f1_ff.dz;
      f2_in.bond = f1_ff.bond;
      f2_in.r    = f1_ff.r;
      f2_in.fb   = mpf_pkg::qmul({f1_ff.f[31], f1_ff.f}, {16'h0, f1_ff.bond});
      f2_in.e1   = f1_ff.e1;
      f2_in.e2   = mpf_pkg::qmul({f1_ff.e2a[31], f1_ff.e2a}, mpf_pkg::Q_HALF);
   end

   assign num_fs = mpf_pkg::NUM_W'({mpf_pkg::mag32(f2_ff.fb), 16'h0})
                 + mpf_pkg::NUM_W'(f2_ff.r[31:1]);

   mpf_div u_div_fs (
      .clock (clock),
      .en    (en),
      .num   (num_fs),
      .den   (f2_ff.r),
      .quot  (q_fs),
      .ovf   (ovf_fs)
   );

   always_comb begin
      p4_in.vld  = f2_ff.vld;
      p4_in.hit  = f2_ff.hit;
      p4_in.dx   = f2_ff.dx;
      p4_in.dy   = f2_ff.dy;
      p4_in.dz   = f2_ff.dz;
      p4_in.bond = f2_ff.bond;
      p4_in.e1   = f2_ff.e1;
      p4_in.e2   = f2_ff.e2;
      p4_in.neg  = f2_ff.fb[31];
   end

   always_comb begin
      fs_pl_type t;
      t          = p4_ff[mpf_pkg::STEP_D-1];
      g1_in.vld  = t.vld;
      g1_in.hit  = t.hit;
      g1_in.dx   = t.dx;
      g1_in.dy   = t.dy;
      g1_in.dz   = t.dz;
      g1_in.bond = t.bond;
      g1_in.fs   = mpf_pkg::sdiv(q_fs, ovf_fs, t.neg);
      g1_in.esum = mpf_pkg::sat32(mpf_pkg::sx36(t.e1) + mpf_pkg::sx36(t.e2));
   end

   always_comb begin
      g2_in.vld = g1_ff.vld;
      g2_in.d   = '0;
      if (g1_ff.hit) begin
         g2_in.d.hit = 1'b1;
         g2_in.d.fs  = g1_ff.fs;
         g2_in.d.fx  = mpf_pkg::qmul({g1_ff.dx[31], g1_ff.dx}, {g1_ff.fs[31], g1_ff.fs});
         g2_in.d.fy  = mpf_pkg::qmul({g1_ff.dy[31], g1_ff.dy}, {g1_ff.fs[31], g1_ff.fs});
         g2_in.d.fz  = mpf_pkg::qmul({g1_ff.dz[31], g1_ff.dz}, {g1_ff.fs[31], g1_ff.fs});
         if (energy_en_ff) begin
            g2_in.d.energy = mpf_pkg::qmul({g1_ff.esum[31], g1_ff.esum},
                                           {16'h0, g1_ff.bond});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff  <= '0;
         b_ff  <= '0;
         c_ff  <= '0;
         w_ff  <= '0;
         m1_ff <= '0;
         m2_ff <= '0;
         m3_ff <= '0;
         f1_ff <= '0;
         f2_ff <= '0;
         g1_ff <= '0;
         g2_ff <= '0;
         for (int k = 0; k < mpf_pkg::STEP_D; k++) begin
            p1_ff[k] <= '0;
            p2_ff[k] <= '0;
            p3_ff[k] <= '0;
            p4_ff[k] <= '0;
         end
      end else if (en) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         w_ff     <= w_in;
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         m3_ff    <= m3_in;
         f1_ff    <= f1_in;
         f2_ff    <= f2_in;
         g1_ff    <= g1_in;
         g2_ff    <= g2_in;
         p1_ff[0] <= p1_in;
         p2_ff[0] <= p2_in;
         p3_ff[0] <= p3_in;
         p4_ff[0] <= p4_in;
         for (int k = 1; k < mpf_pkg::STEP_D; k++) begin
            p1_ff[k] <= p1_ff[k-1];
            p2_ff[k] <= p2_ff[k-1];
            p3_ff[k] <= p3_ff[k-1];
            p4_ff[k] <= p4_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= g2_ff.vld;
         end
      end else if (g2_ff.vld) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_tready) begin
         out_ff <= skid_vld_ff ? skid_ff : g2_ff.d;
      end else if (en) begin
         skid_ff <= g2_ff.d;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.energy, out_ff.fs, out_ff.fz, out_ff.fy, out_ff.fx};
   assign rsp_tuser  = out_ff.hit;

endmodule
